// ===== src/rrb_pkg.sv =====
// Shared types and constants for the RGBA region blend blitter.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package rrb_pkg;

    localparam int CfgW     = 11;
    localparam int CfgIdxW  = 3;
    localparam int PosW     = 10;
    localparam int ChanW    = 8;
    localparam int AddrW    = 20;
    localparam int InDataW  = 88;
    localparam int OutDataW = 56;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEST_X     = 3'd0,
        REG_DEST_Y     = 3'd1,
        REG_SRC_WIDTH  = 3'd2,
        REG_SRC_HEIGHT = 3'd3,
        REG_FRAME_DIM  = 3'd4,
        REG_BLEND_MODE = 3'd5
    } rrb_reg_t;

    typedef enum logic [1:0] {
        BLEND_REPLACE = 2'd0,
        BLEND_SAT_ADD = 2'd1,
        BLEND_ALPHA   = 2'd2
    } rrb_blend_t;

    // Channel order within a pixel: 0 red, 1 green, 2 blue, 3 alpha.
    typedef logic [3:0][ChanW-1:0] rrb_pixel_t;

    typedef struct packed {
        logic signed [CfgW-1:0] dest_x;
        logic signed [CfgW-1:0] dest_y;
        logic [CfgW-1:0]        src_width;
        logic [CfgW-1:0]        src_height;
        logic [CfgW-1:0]        dim;         // frame_dim clamped to MAX_DIM
        logic [1:0]             blend_mode;
    } rrb_cfg_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } rrb_stage_en_t;

endpackage
`default_nettype wire

// ===== src/rrb_cfg.sv =====
// Configuration register file of the blitter stage.
// Depends on rrb_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none
module rrb_cfg #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rrb_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rrb_pkg::CfgW-1:0]     cfg_data,
    output rrb_pkg::rrb_cfg_t                 cfg
);

    localparam int          DimCmpW   = 14;
    localparam logic [DimCmpW-1:0] MaxDimC = DimCmpW'(MAX_DIM);
    localparam int          ResetDim  = (MAX_DIM < 1024) ? MAX_DIM : 1024;

    rrb_pkg::rrb_cfg_t cfg_reg;
    rrb_pkg::rrb_cfg_t cfg_next;
    logic [rrb_pkg::CfgW-1:0] dim_clamped;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Clamp the frame size once, at write time.
    always_comb begin
        if ({{(DimCmpW-rrb_pkg::CfgW){1'b0}}, cfg_data} > MaxDimC) begin
            dim_clamped = MaxDimC[rrb_pkg::CfgW-1:0];
        end else begin
            dim_clamped = cfg_data;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rrb_pkg::REG_DEST_X:     cfg_next.dest_x     = $signed(cfg_data);
                rrb_pkg::REG_DEST_Y:     cfg_next.dest_y     = $signed(cfg_data);
                rrb_pkg::REG_SRC_WIDTH:  cfg_next.src_width  = cfg_data;
                rrb_pkg::REG_SRC_HEIGHT: cfg_next.src_height = cfg_data;
                rrb_pkg::REG_FRAME_DIM:  cfg_next.dim        = dim_clamped;
                rrb_pkg::REG_BLEND_MODE: cfg_next.blend_mode = cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x     <= '0;
            cfg_reg.dest_y     <= '0;
            cfg_reg.src_width  <= '0;
            cfg_reg.src_height <= '0;
            cfg_reg.dim        <= rrb_pkg::CfgW'(ResetDim);
            cfg_reg.blend_mode <= rrb_pkg::BLEND_ALPHA;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/rrb_geom.sv =====
// Position, clipping and address pipeline, three register stages.
// Depends on rrb_pkg; stage loads come from the top level.
`timescale 1ns / 1ps
`default_nettype none
module rrb_geom (
    input  wire logic                        aclk,
    input  wire rrb_pkg::rrb_stage_en_t      en,
    input  wire rrb_pkg::rrb_cfg_t           cfg,
    input  wire logic [rrb_pkg::PosW-1:0]    src_col,
    input  wire logic [rrb_pkg::PosW-1:0]    src_row,
    output logic                             ok_s2,
    output logic                             write_enable,
    output logic [rrb_pkg::AddrW-1:0]        pixel_address
);

    localparam int TW = rrb_pkg::CfgW + 1;
    localparam int PW = 2 * rrb_pkg::CfgW;

    // stage 1
    logic signed [TW-1:0] tx_reg, tx_next;
    logic signed [TW-1:0] ty_reg, ty_next;
    logic                 in_src_reg, in_src_next;
    // stage 2
    logic [rrb_pkg::CfgW-1:0] tx2_reg;
    logic [PW-1:0]            prod_reg, prod_next;
    logic                     ok2_reg, ok2_next;
    // stage 3
    logic                     we_reg, we_next;
    logic [rrb_pkg::AddrW-1:0] addr_reg, addr_next;

    always_comb begin
        tx_next = $signed({cfg.dest_x[rrb_pkg::CfgW-1], cfg.dest_x})
                + $signed({2'b00, src_col});
        ty_next = $signed({cfg.dest_y[rrb_pkg::CfgW-1], cfg.dest_y})
                + $signed({2'b00, src_row});
        in_src_next = ({1'b0, src_col} < cfg.src_width)
                   && ({1'b0, src_row} < cfg.src_height);
    end

    always_comb begin
        ok2_next = in_src_reg && !tx_reg[TW-1] && !ty_reg[TW-1]
                && (tx_reg[TW-2:0] < cfg.dim) && (ty_reg[TW-2:0] < cfg.dim);
        prod_next = ty_reg[TW-2:0] * cfg.dim;
    end

    always_comb begin
        we_next   = ok2_reg;
        addr_next = '0;
        if (ok2_reg) begin
            addr_next = prod_reg[rrb_pkg::AddrW-1:0]
                      + {{(rrb_pkg::AddrW-rrb_pkg::CfgW){1'b0}}, tx2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            in_src_reg <= in_src_next;
        end
        if (en.ld2) begin
            tx2_reg  <= tx_reg[TW-2:0];
            prod_reg <= prod_next;
            ok2_reg  <= ok2_next;
        end
        if (en.ld3) begin
            we_reg   <= we_next;
            addr_reg <= addr_next;
        end
    end

    assign ok_s2         = ok2_reg;
    assign write_enable  = we_reg;
    assign pixel_address = addr_reg;

endmodule
`default_nettype wire

// ===== src/rrb_blend.sv =====
// Colour pipeline: replace, saturating add or source-alpha blend.
// Depends on rrb_pkg; three register stages in step with rrb_geom.
`timescale 1ns / 1ps
`default_nettype none
module rrb_blend (
    input  wire logic                     aclk,
    input  wire rrb_pkg::rrb_stage_en_t   en,
    input  wire rrb_pkg::rrb_cfg_t        cfg,
    input  wire rrb_pkg::rrb_pixel_t      src_px,
    input  wire rrb_pkg::rrb_pixel_t      dst_px,
    input  wire logic                     ok_s2,
    output rrb_pkg::rrb_pixel_t           out_px
);

    localparam int CW = rrb_pkg::ChanW;
    localparam int MW = 2 * CW;
    localparam logic [CW-1:0] Full = {CW{1'b1}};

    // stage 1: products
    logic [2:0][MW-1:0]  pa_reg, pa_next;
    logic [2:0][MW-1:0]  pb_reg, pb_next;
    rrb_pkg::rrb_pixel_t src1_reg, dst1_reg;
    // stage 2: sums
    logic [2:0][MW-1:0]  sum_reg, sum_next;
    rrb_pkg::rrb_pixel_t src2_reg, dst2_reg;
    // stage 3: result
    rrb_pkg::rrb_pixel_t out_reg, out_next;

    logic [CW-1:0] inv_alpha;
    logic [2:0][CW-1:0] quot;
    logic [3:0][CW-1:0] sat;
    logic [MW:0]   div_acc [3];
    logic [CW:0]   add_sum [4];

    assign inv_alpha = Full - src_px[3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_next[i] = src_px[i] * src_px[3];
            pb_next[i] = dst_px[i] * inv_alpha;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = pa_reg[i] + pb_reg[i];
        end
    end

    // Divide by 255: exact for sums up to 255 * 255.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_acc[i] = {1'b0, sum_reg[i]} + {{(CW+1){1'b0}}, sum_reg[i][MW-1:CW]}
                       + (MW+1)'(1);
            quot[i]    = div_acc[i][MW-1:CW];
        end
        for (int i = 0; i < 4; i++) begin
            add_sum[i] = {1'b0, src2_reg[i]} + {1'b0, dst2_reg[i]};
            sat[i]     = add_sum[i][CW] ? Full : add_sum[i][CW-1:0];
        end
    end

    always_comb begin
        out_next = '0;
        if (ok_s2) begin
            case (cfg.blend_mode)
                rrb_pkg::BLEND_REPLACE: out_next = src2_reg;
                rrb_pkg::BLEND_SAT_ADD: out_next = sat;
                default: begin
                    out_next[0] = quot[0];
                    out_next[1] = quot[1];
                    out_next[2] = quot[2];
                    out_next[3] = src2_reg[3];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            src1_reg <= src_px;
            dst1_reg <= dst_px;
        end
        if (en.ld2) begin
            sum_reg  <= sum_next;
            src2_reg <= src1_reg;
            dst2_reg <= dst1_reg;
        end
        if (en.ld3) begin
            out_reg <= out_next;
        end
    end

    assign out_px = out_reg;

endmodule
`default_nettype wire

// ===== src/rgba_region_blend_blit.sv =====
// Top level of the RGBA region blend blitter: stage valid bits and loads,
// config file, geometry and colour pipelines. Depends on rrb_pkg and all rrb_* modules.
//
//   channel   ports          request contents
//   input     s_t*           one source pixel, its position and the destination pixel
//   output    m_t*           write enable, frame address and colour to write
//   config    cfg_*          register index and write data
//
// One pixel per clock while m_tready lets the output stage advance; an accepted request
// moves through stage 1 and stage 2 into the output stage, whose valid bit is m_tvalid.
// There are three register stages: sum/product, multiply/add, divide/select.
// aresetn (synchronous) clears valid bits and the config registers to their defaults.
// With m_tready low the last stage holds; earlier stages keep filling until full.
`timescale 1ns / 1ps
`default_nettype none
module rgba_region_blend_blit #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [9:0] src_col, [19:10] src_row, [27:20] src_red, [35:28] src_green,
    // [43:36] src_blue, [51:44] src_alpha, [59:52] dst_red, [67:60] dst_green,
    // [75:68] dst_blue, [83:76] dst_alpha, [87:84] zero
    input  wire logic [rrb_pkg::InDataW-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] write_enable, [20:1] pixel_address, [28:21] out_red, [36:29] out_green,
    // [44:37] out_blue, [52:45] out_alpha, [55:53] zero
    output logic [rrb_pkg::OutDataW-1:0]       m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rrb_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [rrb_pkg::CfgW-1:0]      cfg_data
);

    rrb_pkg::rrb_cfg_t      cfg;
    rrb_pkg::rrb_stage_en_t en;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    logic                          ok_s2;
    logic                          write_enable;
    logic [rrb_pkg::AddrW-1:0]     pixel_address;
    rrb_pkg::rrb_pixel_t           out_px;

    // advance a stage when it is empty or its successor advances
    always_comb begin
        en.ld3 = !v3_reg || m_tready;
        en.ld2 = !v2_reg || en.ld3;
        en.ld1 = !v1_reg || en.ld2;
    end

    assign s_tready = en.ld1;

    always_comb begin
        v1_next = en.ld1 ? s_tvalid : v1_reg;
        v2_next = en.ld2 ? v1_reg   : v2_reg;
        v3_next = en.ld3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    rrb_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rrb_geom u_geom (
        .aclk          (aclk),
        .en            (en),
        .cfg           (cfg),
        .src_col       (s_tdata[9:0]),
        .src_row       (s_tdata[19:10]),
        .ok_s2         (ok_s2),
        .write_enable  (write_enable),
        .pixel_address (pixel_address)
    );

    rrb_blend u_blend (
        .aclk   (aclk),
        .en     (en),
        .cfg    (cfg),
        .src_px (s_tdata[51:20]),
        .dst_px (s_tdata[83:52]),
        .ok_s2  (ok_s2),
        .out_px (out_px)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {3'b000, out_px, pixel_address, write_enable};

`ifndef NO_ASSERTIONS
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted request did not enter stage 1");

    a_stage2_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && en.ld3 |=> v3_reg)
        else $error("stage 2 request lost on its way to the output");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !m_tready |=> v3_reg && $stable(m_tdata))
        else $error("output stage changed under stall");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[52:1] == '0)
        else $error("dropped pixel carries nonzero address or colour");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for rgba_region_blend_blit: clipping, pixel address and blend modes.
// A queued pixel driver and a result monitor check the block against a predictor kept here.
// Depends on rrb_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb_top;

    localparam int ChanW      = rrb_pkg::ChanW;
    localparam int PosW       = rrb_pkg::PosW;
    localparam int AddrW      = rrb_pkg::AddrW;
    localparam int CfgW       = rrb_pkg::CfgW;
    localparam int CfgIdxW    = rrb_pkg::CfgIdxW;
    localparam int InDataW    = rrb_pkg::InDataW;
    localparam int OutDataW   = rrb_pkg::OutDataW;
    localparam int MaxDim     = 1024;
    localparam int ChanMax    = 255;
    localparam int NumPhases  = 12;
    localparam int PhaseItems = 90;
    localparam int LongHold   = 80;
    localparam int PipeSettle = 8;
    localparam int WatchLimit = 2000;
    localparam int MaxPrints  = 100;
    localparam logic [1:0] BLEND_UNUSED = 2'd3;
    localparam logic [1:0] ModeSeq [4] = '{rrb_pkg::BLEND_REPLACE, rrb_pkg::BLEND_SAT_ADD,
                                           rrb_pkg::BLEND_ALPHA, BLEND_UNUSED};

    typedef struct packed {
        logic [ChanW-1:0] dst_alpha, dst_blue, dst_green, dst_red;
        logic [ChanW-1:0] src_alpha, src_blue, src_green, src_red;
        logic [PosW-1:0]  src_row, src_col;
    } pix_req_t;

    typedef struct packed {
        logic [ChanW-1:0] out_alpha, out_blue, out_green, out_red;
        logic [AddrW-1:0] pixel_address;
        logic             write_enable;
    } pix_write_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [InDataW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0] cfg_data = '0;

    // Shadow of the block's registers, reset values.
    logic signed [CfgW-1:0] cfg_dx = '0;
    logic signed [CfgW-1:0] cfg_dy = '0;
    logic [CfgW-1:0] cfg_sw = '0;
    logic [CfgW-1:0] cfg_sh = '0;
    logic [CfgW-1:0] cfg_fd = CfgW'(MaxDim);
    logic [1:0] cfg_bm = rrb_pkg::BLEND_ALPHA;

    pix_req_t pixel_queue[$];
    pix_write_t expected_writes[$];
    pix_req_t drv_pix;
    logic idle_on = 1'b1;
    int tx_gap = 0;
    int rx_gap = 0;
    int rx_hold = 0;
    int writes_seen = 0;
    int err_count = 0;
    int stall_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgba_region_blend_blit #(
        .MAX_DIM(MaxDim)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    function automatic pix_write_t blend_pixel(pix_req_t p);
        pix_write_t r;
        rrb_pkg::rrb_pixel_t sc, dc, oc;
        int tx, ty, dim, sum;
        r = '0;
        oc = '0;
        sc = {p.src_alpha, p.src_blue, p.src_green, p.src_red};
        dc = {p.dst_alpha, p.dst_blue, p.dst_green, p.dst_red};
        dim = (int'(cfg_fd) > MaxDim) ? MaxDim : int'(cfg_fd);
        tx = int'(cfg_dx) + int'(p.src_col);
        ty = int'(cfg_dy) + int'(p.src_row);
        if (p.src_col < cfg_sw && p.src_row < cfg_sh && tx >= 0 && ty >= 0 &&
            tx < dim && ty < dim) begin
            for (int i = 0; i < 4; i++) begin
                case (cfg_bm)
                    rrb_pkg::BLEND_REPLACE: oc[i] = sc[i];
                    rrb_pkg::BLEND_SAT_ADD: begin
                        sum = int'(sc[i]) + int'(dc[i]);
                        oc[i] = (sum > ChanMax) ? ChanW'(ChanMax) : ChanW'(sum);
                    end
                    default: begin
                        if (i == 3)
                            oc[i] = sc[3];
                        else
                            oc[i] = ChanW'((int'(sc[i]) * int'(sc[3]) +
                                            int'(dc[i]) * (ChanMax - int'(sc[3]))) / ChanMax);
                    end
                endcase
            end
            r.write_enable = 1'b1;
            r.pixel_address = AddrW'(ty * dim + tx);
            {r.out_alpha, r.out_blue, r.out_green, r.out_red} = oc;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= MaxPrints)
            $display("ERROR @%0t result %0d: %s got 0x%0h want 0x%0h",
                     $time, writes_seen, field, got, want);
    endtask

    // Driver: offer queued pixel requests, predict each one when accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_writes.push_back(blend_pixel(drv_pix));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    drv_pix = pixel_queue.pop_front();
                    s_tdata <= InDataW'(drv_pix);
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        tx_gap = $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random.
    always @(posedge aclk) begin
        pix_write_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = pix_write_t'(m_tdata[$bits(pix_write_t)-1:0]);
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got), 32'(0));
                end else begin
                    want = expected_writes.pop_front();
                    if (got.write_enable !== want.write_enable)
                        report_mismatch("write_enable", 32'(got.write_enable),
                                        32'(want.write_enable));
                    if (got.pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", 32'(got.pixel_address),
                                        32'(want.pixel_address));
                    if (got.out_red !== want.out_red)
                        report_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
                    if (got.out_green !== want.out_green)
                        report_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
                    if (got.out_blue !== want.out_blue)
                        report_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
                    if (got.out_alpha !== want.out_alpha)
                        report_mismatch("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
                end
                writes_seen++;
                if (writes_seen == 150 || writes_seen == 600)
                    rx_hold = LongHold;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    rx_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WatchLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(rrb_pkg::rrb_reg_t idx, logic [CfgW-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rrb_pkg::REG_DEST_X:     cfg_dx = val;
            rrb_pkg::REG_DEST_Y:     cfg_dy = val;
            rrb_pkg::REG_SRC_WIDTH:  cfg_sw = val;
            rrb_pkg::REG_SRC_HEIGHT: cfg_sh = val;
            rrb_pkg::REG_FRAME_DIM:  cfg_fd = val;
            rrb_pkg::REG_BLEND_MODE: cfg_bm = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int dx, int dy, int sw, int sh, int fd, logic [1:0] bm);
        write_reg(rrb_pkg::REG_DEST_X, CfgW'(dx));
        write_reg(rrb_pkg::REG_DEST_Y, CfgW'(dy));
        write_reg(rrb_pkg::REG_SRC_WIDTH, CfgW'(sw));
        write_reg(rrb_pkg::REG_SRC_HEIGHT, CfgW'(sh));
        write_reg(rrb_pkg::REG_FRAME_DIM, CfgW'(fd));
        write_reg(rrb_pkg::REG_BLEND_MODE, CfgW'(bm));
        @(negedge aclk);
    endtask

    // Hold until every request is accepted and every result is back.
    task automatic drain();
        do @(negedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || expected_writes.size() != 0);
        repeat (PipeSettle) @(negedge aclk);
    endtask

    task automatic push_pixel(int col, int row, logic [31:0] src, logic [31:0] dst);
        pix_req_t p;
        p.src_col = PosW'(col);
        p.src_row = PosW'(row);
        {p.src_alpha, p.src_blue, p.src_green, p.src_red} = src;
        {p.dst_alpha, p.dst_blue, p.dst_green, p.dst_red} = dst;
        pixel_queue.push_back(p);
    endtask

    function automatic logic [ChanW-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return ChanW'($urandom);
        endcase
    endfunction

    // Mostly pixels inside the source rectangle, the rest anywhere.
    task automatic queue_random_pixels(int n);
        pix_req_t p;
        int lim_w, lim_h;
        lim_w = (int'(cfg_sw) > MaxDim) ? MaxDim : int'(cfg_sw);
        lim_h = (int'(cfg_sh) > MaxDim) ? MaxDim : int'(cfg_sh);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0 && lim_w != 0 && lim_h != 0) begin
                p.src_col = PosW'($urandom_range(0, lim_w - 1));
                p.src_row = PosW'($urandom_range(0, lim_h - 1));
            end else begin
                p.src_col = PosW'($urandom);
                p.src_row = PosW'($urandom);
            end
            p.src_red = rand_chan();
            p.src_green = rand_chan();
            p.src_blue = rand_chan();
            p.src_alpha = rand_chan();
            p.dst_red = rand_chan();
            p.dst_green = rand_chan();
            p.dst_blue = rand_chan();
            p.dst_alpha = rand_chan();
            pixel_queue.push_back(p);
        end
    endtask

    initial begin : stimulus
        int fd, sw, sh, dx, dy;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty source after reset: everything dropped.
        push_pixel(5, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_pixel(0, 0, 32'h1234_5678, 32'h0);
        drain();

        set_regs(0, 0, MaxDim, MaxDim, MaxDim, rrb_pkg::BLEND_REPLACE);
        push_pixel(0, 0, 32'hFFFF_FFFF, 32'h0);
        push_pixel(1023, 1023, 32'h0, 32'hFFFF_FFFF);
        push_pixel(1023, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        push_pixel(0, 1023, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        drain();

        set_regs(0, 0, MaxDim, MaxDim, MaxDim, rrb_pkg::BLEND_SAT_ADD);
        push_pixel(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_pixel(2, 2, 32'h0, 32'h0);
        push_pixel(3, 3, 32'h80C8_64FF, 32'h8064_9B10);
        drain();

        // Clip at the left and bottom of a small frame and at the source width, alpha extremes.
        set_regs(-5, -5, 20, 24, 16, rrb_pkg::BLEND_ALPHA);
        push_pixel(5, 5, 32'h00FF_8040, 32'hFF10_20F0);
        push_pixel(6, 6, 32'hFF12_3456, 32'hFFAB_CDEF);
        push_pixel(10, 10, 32'h80FF_0080, 32'h1000_FF7F);
        push_pixel(4, 5, 32'hFFFF_FFFF, 32'h0);
        push_pixel(19, 19, 32'h7F01_FE33, 32'hC0FF_00EE);
        push_pixel(20, 5, 32'hFFFF_FFFF, 32'h0);
        push_pixel(5, 21, 32'hFFFF_FFFF, 32'h0);
        drain();

        // Oversized frame and the unused blend mode.
        set_regs(1023, 0, 2047, 2047, 2047, BLEND_UNUSED);
        push_pixel(0, 0, 32'h40FF_8000, 32'h00FF_FFFF);
        push_pixel(1, 0, 32'hFFFF_FFFF, 32'h0);
        push_pixel(0, 1023, 32'hC033_6699, 32'h5511_2299);
        drain();

        set_regs(0, 0, MaxDim, MaxDim, 0, rrb_pkg::BLEND_REPLACE);
        push_pixel(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < NumPhases; ph++) begin
            fd = (ph == 0) ? 1 :
                 (ph == 1 || ph == 6) ? MaxDim :
                 (ph == 2) ? 2047 :
                 ($urandom_range(0, 1) != 0) ? int'($urandom_range(8, 64)) :
                                               int'($urandom_range(1, MaxDim));
            sw = (ph == 3) ? 2047 :
                 ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 64)) :
                                               int'($urandom_range(1, MaxDim));
            sh = (ph == 4) ? MaxDim :
                 ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 64)) :
                                               int'($urandom_range(1, MaxDim));
            dx = (ph == 5) ? -1024 :
                 (ph == 6) ? 1023 :
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2047)) - 1024 :
                                               int'($urandom_range(0, 16)) - 8;
            dy = (ph == 7) ? -1024 :
                 (ph == 8) ? 1023 :
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2047)) - 1024 :
                                               int'($urandom_range(0, 16)) - 8;
            idle_on = (ph % 3 != 2) && (ph != NumPhases - 1);
            set_regs(dx, dy, sw, sh, fd, ModeSeq[ph % 4]);
            queue_random_pixels(PhaseItems);
            drain();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
